// File: design/sha1h_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher package
// Shared constants, types and round helpers for the SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1h_pkg;

   // Initial chaining values
   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hefcdab89;
   localparam logic [31:0] IV2 = 32'h98badcfe;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hc3d2e1f0;

   // Round constants, one per group of twenty rounds
   localparam logic [31:0] K0 = 32'h5a827999;
   localparam logic [31:0] K1 = 32'h6ed9eba1;
   localparam logic [31:0] K2 = 32'h8f1bbcdc;
   localparam logic [31:0] K3 = 32'hca62c1d6;

   localparam logic [7:0] PAD_MARK     = 8'h80;
   localparam int         ROUNDS       = 80;
   localparam int         DIGEST_WORDS = 5;
   localparam int         BLOCK_BITS   = 512;
   localparam logic [5:0] LEN_POS      = 6'd56;
   localparam logic [5:0] LAST_POS     = 6'd63;

   // Action codes carried on the request tuser
   localparam logic ACT_ABSORB = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ROUND = 5'b00010,
      ST_ADD   = 5'b00100,
      ST_PAD   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   // Working variables of the compression
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
   } work_type;

   // One result transaction
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } rsp_item_type;

   function automatic logic [31:0] rotl1(input logic [31:0] x);
      return {x[30:0], x[31]};
   endfunction

   // Round constant by round number
   function automatic logic [31:0] round_k(input logic [6:0] rnd);
      logic [31:0] k;
      if (rnd < 7'd20) begin
         k = K0;
      end else if (rnd < 7'd40) begin
         k = K1;
      end else if (rnd < 7'd60) begin
         k = K2;
      end else begin
         k = K3;
      end
      return k;
   endfunction

   // Boolean function by round number
   function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      if (rnd < 7'd20) begin
         f = ((c ^ d) & b) ^ d;
      end else if (rnd < 7'd40) begin
         f = b ^ c ^ d;
      end else if (rnd < 7'd60) begin
         f = (b & c) | (d & (b | c));
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

endpackage

// File: design/sha1h_round.sv
// ----------------------------------------------------------------------------
// SHA-1 round unit
// One compression round plus one message schedule expansion step.
// ----------------------------------------------------------------------------
module sha1h_round (
   input  sha1h_pkg::work_type                     work,
   input  logic [6:0]                              rnd,
   input  logic [sha1h_pkg::BLOCK_BITS-1:0]        window,
   output sha1h_pkg::work_type                     work_next,
   output logic [31:0]                             w_new
);
   import sha1h_pkg::*;

   logic [31:0] w0;
   logic [31:0] w2;
   logic [31:0] w8;
   logic [31:0] w13;
   logic [31:0] temp;

   // Window taps: word j sits at the j-th 32-bit slot from the top
   assign w0  = window[BLOCK_BITS-1        -: 32];
   assign w2  = window[BLOCK_BITS-1-32*2   -: 32];
   assign w8  = window[BLOCK_BITS-1-32*8   -: 32];
   assign w13 = window[BLOCK_BITS-1-32*13  -: 32];

   // Expand the schedule by one word
   assign w_new = rotl1(w13 ^ w8 ^ w2 ^ w0);

   // Round sum and rotate of the working variables
   assign temp = {work.a[26:0], work.a[31:27]} + round_f(rnd, work.b, work.c, work.d)
                 + work.e + w0 + round_k(rnd);

   assign work_next.a = temp;
   assign work_next.b = work.a;
   assign work_next.c = {work.b[1:0], work.b[31:2]};
   assign work_next.d = work.c;
   assign work_next.e = work.d;

endmodule

// File: design/sha1h_out_reg.sv
// ----------------------------------------------------------------------------
// SHA-1 output register
// Holds one digest word transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module sha1h_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  sha1h_pkg::rsp_item_type item,
   output logic                    push_ready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata,   // [31:0] digest_word
   output logic [2:0]              rsp_tuser,   // [2:0] word_index
   output logic                    rsp_tlast    // last_word
);
   import sha1h_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;
   rsp_item_type item_in;

   // Take a new word when empty or when the held one leaves
   assign push_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (push_ready) begin
         valid_in = push;
         if (push) begin
            item_in = item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = item_ff.word;
   assign rsp_tuser  = item_ff.index;
   assign rsp_tlast  = item_ff.last;

endmodule

// File: design/sha1_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Hashes a message fed one byte per transaction and returns its digest.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser is the action (absorb or finish), tdata the message
//   byte. The byte that completes a 64-byte block starts a compression: the
//   byte is taken, then the single round unit runs the 80 rounds, one round
//   per cycle, and the chaining add follows.
//   A finish transaction feeds the padding one byte per cycle (9 to 72 bytes)
//   with one or two compressions on the way, then emits five digest words.
//   rsp channel: tdata is the digest word, tuser its index (0 is most
//   significant), tlast marks the fifth word. Words leave through an output
//   register, so the block takes the next request while the last word waits.
//   req_tready is high only while the sequencer is idle.
//   A stalled receiver holds the sequencer between digest words.
//   Reset loads the initial chaining values and clears the length count;
//   after the fifth word the block returns to the same state by itself.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);
   import sha1h_pkg::*;

   state_type              state_ff, state_in;
   logic [31:0]            chain_ff [DIGEST_WORDS];
   logic [31:0]            chain_in [DIGEST_WORDS];
   logic [BLOCK_BITS-1:0]  block_ff, block_in;
   logic [5:0]             count_ff, count_in;
   logic [63:0]            len_ff, len_in;
   work_type               work_ff, work_in;
   logic [6:0]             rnd_ff, rnd_in;
   logic                   fin_ff, fin_in;
   logic                   mark_ff, mark_in;
   logic                   lenph_ff, lenph_in;
   logic [2:0]             oidx_ff, oidx_in;

   logic                   byte_valid;
   logic [7:0]             byte_val;
   work_type               work_next;
   logic [31:0]            w_new;
   logic                   push;
   logic                   push_ready;
   rsp_item_type           item;

   // Shared round unit
   sha1h_round u_round (
      .work      (work_ff),
      .rnd       (rnd_ff),
      .window    (block_ff),
      .work_next (work_next),
      .w_new     (w_new)
   );

   // Output register
   sha1h_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .item       (item),
      .push_ready (push_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   assign req_tready = (state_ff == ST_IDLE);

   // Present the current digest word
   assign item.word  = chain_ff[oidx_ff];
   assign item.index = oidx_ff;
   assign item.last  = (oidx_ff == 3'(DIGEST_WORDS - 1));

   // Sequencer
   always_comb begin
      state_in = state_ff;
      chain_in = chain_ff;
      block_in = block_ff;
      count_in = count_ff;
      len_in   = len_ff;
      work_in  = work_ff;
      rnd_in   = rnd_ff;
      fin_in   = fin_ff;
      mark_in  = mark_ff;
      lenph_in = lenph_ff;
      oidx_in  = oidx_ff;
      byte_valid = 1'b0;
      byte_val   = 8'h00;
      push       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == ACT_ABSORB) begin
                  byte_valid = 1'b1;
                  byte_val   = req_tdata;
                  len_in     = len_ff + 64'd8;
               end else begin
                  fin_in   = 1'b1;
                  mark_in  = 1'b1;
                  lenph_in = 1'b0;
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // Feed marker, then zeros up to byte 56, then the length
            byte_valid = 1'b1;
            if (mark_ff) begin
               byte_val = PAD_MARK;
               mark_in  = 1'b0;
            end else if (!lenph_ff && count_ff != LEN_POS) begin
               byte_val = 8'h00;
            end else begin
               byte_val = len_ff[63:56];
               len_in   = {len_ff[55:0], 8'h00};
               lenph_in = 1'b1;
            end
         end
         ST_ROUND: begin
            // Advance one round and slide the schedule window
            work_in  = work_next;
            block_in = {block_ff[BLOCK_BITS-33:0], w_new};
            rnd_in   = rnd_ff + 7'd1;
            if (rnd_ff == 7'(ROUNDS - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            chain_in[0] = chain_ff[0] + work_ff.a;
            chain_in[1] = chain_ff[1] + work_ff.b;
            chain_in[2] = chain_ff[2] + work_ff.c;
            chain_in[3] = chain_ff[3] + work_ff.d;
            chain_in[4] = chain_ff[4] + work_ff.e;
            oidx_in     = 3'd0;
            if (fin_ff) begin
               state_in = lenph_ff ? ST_OUT : ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            // Emit digest words, then return to the initial state
            if (push_ready) begin
               push    = 1'b1;
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'(DIGEST_WORDS - 1)) begin
                  chain_in[0] = IV0;
                  chain_in[1] = IV1;
                  chain_in[2] = IV2;
                  chain_in[3] = IV3;
                  chain_in[4] = IV4;
                  len_in      = 64'd0;
                  count_in    = 6'd0;
                  fin_in      = 1'b0;
                  lenph_in    = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Shift a byte into the block; start compression on a full block
      if (byte_valid) begin
         block_in = {block_ff[BLOCK_BITS-9:0], byte_val};
         count_in = count_ff + 6'd1;
         if (count_ff == LAST_POS) begin
            state_in  = ST_ROUND;
            rnd_in    = 7'd0;
            work_in.a = chain_ff[0];
            work_in.b = chain_ff[1];
            work_in.c = chain_ff[2];
            work_in.d = chain_ff[3];
            work_in.e = chain_ff[4];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         chain_ff[0] <= IV0;
         chain_ff[1] <= IV1;
         chain_ff[2] <= IV2;
         chain_ff[3] <= IV3;
         chain_ff[4] <= IV4;
         count_ff    <= 6'd0;
         len_ff      <= 64'd0;
         rnd_ff      <= 7'd0;
         fin_ff      <= 1'b0;
         mark_ff     <= 1'b0;
         lenph_ff    <= 1'b0;
         oidx_ff     <= 3'd0;
      end else begin
         state_ff <= state_in;
         chain_ff <= chain_in;
         count_ff <= count_in;
         len_ff   <= len_in;
         rnd_ff   <= rnd_in;
         fin_ff   <= fin_in;
         mark_ff  <= mark_in;
         lenph_ff <= lenph_in;
         oidx_ff  <= oidx_in;
      end
      block_ff <= block_in;
      work_ff  <= work_in;
   end

   // Round counter never passes the last round
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (rnd_ff < 7'(ROUNDS)))
      else $error("round counter out of range");

   // Compression only runs on a freshly completed block
   a_round_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (count_ff == 6'd0))
      else $error("compression with a partial block");

   // Last digest word returns the block to idle with a clean length
   a_finish_clear: assert property (@(posedge clock) disable iff (reset)
      (push && push_ready && item.last) |=>
         (state_ff == ST_IDLE && count_ff == 6'd0 && len_ff == 64'd0))
      else $error("state not cleared after digest");

   // Digest words only go out after the length has been fed
   a_out_after_len: assert property (@(posedge clock) disable iff (reset)
      push |-> (fin_ff && lenph_ff && !mark_ff))
      else $error("digest emitted before padding done");

endmodule

// File: dv/sha1_digest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 digest checker
// Watches the request and result channels of the SHA-1 byte stream hasher.
// Keeps its own hash state, computes the five digest words of every finished
// message and compares each result transaction with the oldest word due.
// ----------------------------------------------------------------------------
module sha1_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] action
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] digest_word
   input  logic [2:0]  rsp_tuser,   // [2:0] word_index
   input  logic        rsp_tlast,   // last_word
   output int          mismatch_count,
   output int          words_due
);
   import sha1h_pkg::*;

   // Hash state of the message in flight
   logic [31:0]  hash_chain [5];
   logic [31:0]  block_words [16];
   logic [5:0]   block_fill;
   logic [63:0]  msg_bits;

   // Digest words computed but not yet seen on the result channel
   rsp_item_type digest_queue [$];
   int           mismatches = 0;

   function automatic logic [31:0] rotate_left(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // Return to the initial chaining values and an empty message
   function automatic void restart_message();
      hash_chain  = '{IV0, IV1, IV2, IV3, IV4};
      block_words = '{default: '0};
      block_fill  = '0;
      msg_bits    = '0;
   endfunction

   // Run the 80 rounds over the current block and fold into the chain
   function automatic void run_compression();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, wt, sum;
      int          t;
      w = block_words;
      a = hash_chain[0];
      b = hash_chain[1];
      c = hash_chain[2];
      d = hash_chain[3];
      e = hash_chain[4];
      for (t = 0; t < ROUNDS; t++) begin
         if (t < 16) begin
            wt = w[t];
         end else begin
            wt = rotate_left(w[(t - 3) & 15] ^ w[(t - 8) & 15] ^ w[(t - 14) & 15] ^
                             w[t & 15], 1);
            w[t & 15] = wt;
         end
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = K0;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = K1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K2;
         end else begin
            f = b ^ c ^ d;
            k = K3;
         end
         sum = rotate_left(a, 5) + f + e + wt + k;
         e   = d;
         d   = c;
         c   = rotate_left(b, 30);
         b   = a;
         a   = sum;
      end
      hash_chain[0] += a;
      hash_chain[1] += b;
      hash_chain[2] += c;
      hash_chain[3] += d;
      hash_chain[4] += e;
   endfunction

   // Shift one byte into the block, big-endian within each word
   function automatic void absorb_byte(input logic [7:0] data);
      logic [3:0] slot;
      slot = block_fill[5:2];
      block_words[slot] = {block_words[slot][23:0], data};
      block_fill = block_fill + 6'd1;
      if (block_fill == '0) begin
         run_compression();
      end
      msg_bits = msg_bits + 64'd8;
   endfunction

   // Pad, append the length, compress and queue the five digest words
   function automatic void finish_message();
      logic [63:0] length_bits;
      int          i;
      length_bits = msg_bits;
      absorb_byte(PAD_MARK);
      while (block_fill != LEN_POS) begin
         absorb_byte(8'h00);
      end
      for (i = 0; i < 8; i++) begin
         absorb_byte(length_bits[63 - 8 * i -: 8]);
      end
      for (i = 0; i < DIGEST_WORDS; i++) begin
         digest_queue.push_back('{word: hash_chain[i], index: 3'(i),
                                  last: (i == DIGEST_WORDS - 1)});
      end
      restart_message();
   endfunction

   // Compare one result transaction with the oldest word due
   function automatic void check_digest_word();
      rsp_item_type due;
      if (digest_queue.size() == 0) begin
         $error("digest word %h index %0d arrived with nothing due", rsp_tdata, rsp_tuser);
         mismatches++;
      end else begin
         due = digest_queue.pop_front();
         if (rsp_tdata !== due.word) begin
            $error("digest_word: expected %h, actual %h", due.word, rsp_tdata);
            mismatches++;
         end
         if (rsp_tuser !== due.index) begin
            $error("word_index: expected %0d, actual %0d", due.index, rsp_tuser);
            mismatches++;
         end
         if (rsp_tlast !== due.last) begin
            $error("last_word: expected %0d, actual %0d", due.last, rsp_tlast);
            mismatches++;
         end
      end
   endfunction

   // Sample both channels at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         restart_message();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_digest_word();
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == ACT_FINISH) begin
               finish_message();
            end else begin
               absorb_byte(req_tdata);
            end
         end
      end
      mismatch_count <= mismatches;
      words_due      <= digest_queue.size();
   end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher testbench
// Feeds directed and random messages byte by byte, with random gaps on the
// request side and random stalls on the result side, including one long
// result stall. A separate checker predicts and compares the digests.
// ----------------------------------------------------------------------------
module tb;
   import sha1h_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 1200;
   localparam int HOLD_AFTER     = 150;
   localparam int ITEM_TARGET    = 370;
   localparam int MIN_MESSAGES   = 12;
   localparam int TAIL_CYCLES    = 300;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic        req_tuser;    // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [31:0] digest_word
   logic [2:0]  rsp_tuser;    // [2:0] word_index
   logic        rsp_tlast;    // last_word

   int mismatch_count;
   int words_due;
   int items_sent    = 0;
   int messages_sent = 0;
   int idle_cycles   = 0;
   bit calm          = 1'b0;
   bit hold_done     = 1'b0;

   sha1_byte_stream_hasher i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   sha1_digest_checker u_digest_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .words_due      (words_due)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Mostly no gap, some short ones, a few long; none while calm
   function automatic int draw_gap();
      int roll;
      if (calm) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         return 0;
      end
      if (roll < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Lean toward the byte extremes and the pad marker
   function automatic logic [7:0] draw_byte();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         return 8'h00;
      end
      if (roll < 16) begin
         return 8'hff;
      end
      if (roll < 20) begin
         return PAD_MARK;
      end
      return 8'($urandom);
   endfunction

   // Mostly short messages, some around the padding and block boundaries
   function automatic int draw_length();
      int boundary [8];
      boundary = '{55, 56, 57, 63, 64, 65, 119, 120};
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(0, 24);
      end
      return boundary[$urandom_range(0, 7)];
   endfunction

   // Offer one request transaction and hold it until accepted
   task automatic send_request(input logic action, input logic [7:0] data);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         req_tuser  <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Stimulus and verdict
   initial begin
      int length;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tuser  <= ACT_ABSORB;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty message, with a nonzero byte on the finish
      send_request(ACT_FINISH, 8'hff);
      // another empty message right behind it
      send_request(ACT_FINISH, 8'h00);
      // the classic three-byte message
      send_request(ACT_ABSORB, 8'h61);
      send_request(ACT_ABSORB, 8'h62);
      send_request(ACT_ABSORB, 8'h63);
      send_request(ACT_FINISH, 8'h00);
      // byte extremes and the pad marker as message data
      send_request(ACT_ABSORB, 8'h00);
      send_request(ACT_ABSORB, 8'hff);
      send_request(ACT_ABSORB, PAD_MARK);
      send_request(ACT_FINISH, 8'h5a);
      send_request(ACT_ABSORB, 8'hff);
      send_request(ACT_FINISH, 8'h00);
      messages_sent = 5;

      // random messages, some of them sent without gaps
      while (items_sent < ITEM_TARGET || messages_sent < MIN_MESSAGES) begin
         calm   = ($urandom_range(0, 5) == 0);
         length = draw_length();
         repeat (length) send_request(ACT_ABSORB, draw_byte());
         send_request(ACT_FINISH, 8'($urandom));
         messages_sent++;
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // drain the digests still due, then watch for strays
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && words_due == 0) begin
         $display("sha1_byte_stream_hasher verification clean");
      end else begin
         $display("sha1_byte_stream_hasher verification failed");
      end
      $finish;
   end

   // Result side: random stalls, plus one long hold to back up the block
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!hold_done && items_sent >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            stall = draw_gap();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("sha1_byte_stream_hasher verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
